/* sv/linear_probe_hash_table_assert.svh */
// Assertion macros shared by the hash table RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Plain condition, checked at every clock edge out of reset.
`define LPHT_CHECK(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("lpht: check failed");

// Same-cycle implication.
`define LPHT_IMPLIES(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("lpht: implication failed");

// Next-cycle implication.
`define LPHT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("lpht: next-cycle check failed");

`endif

/* sv/lpht_pkg.sv */
// Shared types and constants of the linear probing hash table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    localparam int TABLE_SIZE_DEF = 1024;
    localparam int KEY_W          = 64;
    localparam int SLOT_W         = 10;
    localparam int STATUS_W       = 2;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic KIND_SEARCH = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
    } t_entry;

endpackage

`default_nettype wire

/* sv/lpht_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/lpht_mod.sv */
// Home slot unit: 64-bit key modulo the table size.
// Depends on lpht_pkg. Power-of-two sizes take a mask; others reduce a nibble a cycle.
`timescale 1ns / 1ps
`default_nettype none

module lpht_mod #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [lpht_pkg::KEY_W-1:0]    i_key,
    output logic                               o_done,
    output logic      [$clog2(TABLE_SIZE)-1:0] o_rem
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    generate
        if ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0) begin : g_pow2
            assign o_done = i_start;
            assign o_rem  = i_key[IDX_W-1:0];
        end else begin : g_serial
            localparam int W     = IDX_W + 4;
            localparam int NIB   = lpht_pkg::KEY_W / 4;
            localparam int CNT_W = $clog2(NIB);

            logic                       r_busy;
            logic                       r_done;
            logic [CNT_W-1:0]           r_cnt;
            logic [IDX_W-1:0]           r_rem;
            logic [lpht_pkg::KEY_W-1:0] r_sh;
            logic [W-1:0]               red;

            // Shift in the next nibble, then fold back below the table size.
            always_comb begin
                red = {r_rem, r_sh[lpht_pkg::KEY_W-1 -: 4]};
                for (int k = 3; k >= 0; k--) begin
                    if (red >= (W'(TABLE_SIZE) << k)) begin
                        red = red - (W'(TABLE_SIZE) << k);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_cnt  <= '0;
                    end else if (r_busy) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                        if (r_cnt == CNT_W'(NIB - 1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= '0;
                    r_sh  <= i_key;
                end else if (r_busy) begin
                    r_rem <= red[IDX_W-1:0];
                    r_sh  <= r_sh << 4;
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end
    endgenerate

endmodule

`default_nettype wire

/* sv/linear_probe_hash_table.sv */
// Channel   Dir  tdata (low bit up)        tuser
// s_axis    in   key[63:0]                 kind (0 search, 1 find or insert)
// m_axis    out  slot[9:0], 6 zero bits    status (found/inserted/not found/full)
//
// One request at a time. With a power-of-two table the home slot comes from a mask, and
// each slot probed takes one RAM read (S_READ) and one check (S_CHECK).
// Other table sizes first run the nibble-serial key modulo (S_HASH).
// After reset a clearing pass writes every slot empty, with s_axis not ready.
// A result waiting on m_axis holds the next one in its done state (S_DONE).
// Top level; depends on lpht_pkg, lpht_mod, lpht_ram and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

`include "linear_probe_hash_table_assert.svh"

module linear_probe_hash_table #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // key[63:0]
    input  wire logic [0:0]  s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // slot[9:0], zeros[15:10]
    output logic      [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int FILL_W = $clog2(TABLE_SIZE + 1);
    localparam int KEY_W  = lpht_pkg::KEY_W;
    localparam int SLOT_W = lpht_pkg::SLOT_W;
    localparam int ST_W   = lpht_pkg::STATUS_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);

    lpht_pkg::t_state r_state, n_state;
    logic               r_kind, n_kind;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [IDX_W-1:0]   r_pos, n_pos;
    logic [IDX_W-1:0]   r_n, n_n;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [ST_W-1:0]    r_res_status, n_res_status;
    logic [SLOT_W-1:0]  r_res_slot, n_res_slot;
    logic               r_out_valid, n_out_valid;
    logic [ST_W-1:0]    r_out_status, n_out_status;
    logic [SLOT_W-1:0]  r_out_slot, n_out_slot;

    logic               accept;
    logic               hash_done;
    logic [IDX_W-1:0]   hash_rem;
    logic               ram_we;
    logic               ram_re;
    lpht_pkg::t_entry   ram_wdata;
    lpht_pkg::t_entry   ram_rd;

    assign s_axis_tready = (r_state == lpht_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16 - SLOT_W){1'b0}}, r_out_slot};
    assign m_axis_tuser  = r_out_status;

    lpht_mod #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   (s_axis_tdata),
        .o_done  (hash_done),
        .o_rem   (hash_rem)
    );

    // Used bit and key share one entry; the clearing pass only needs the used bit.
    lpht_ram #(
        .WIDTH ($bits(lpht_pkg::t_entry)),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_pos),
        .o_rdata (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpht_pkg::S_CLEAR;
            r_pos       <= '0;
            r_n         <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_n         <= n_n;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_key        <= n_key;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_key        = r_key;
        n_pos        = r_pos;
        n_n          = r_n;
        n_fill       = r_fill;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_wdata    = '{used: 1'b0, key: r_key};

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lpht_pkg::S_CLEAR: begin
                ram_we = 1'b1;
                if (r_pos == LAST) begin
                    n_pos   = '0;
                    n_state = lpht_pkg::S_IDLE;
                end else begin
                    n_pos = r_pos + IDX_W'(1);
                end
            end
            lpht_pkg::S_IDLE: begin
                if (accept) begin
                    n_kind = s_axis_tuser[0];
                    n_key  = s_axis_tdata;
                    n_n    = '0;
                    if (hash_done) begin
                        n_pos   = hash_rem;
                        n_state = lpht_pkg::S_READ;
                    end else begin
                        n_state = lpht_pkg::S_HASH;
                    end
                end
            end
            lpht_pkg::S_HASH: begin
                if (hash_done) begin
                    n_pos   = hash_rem;
                    n_state = lpht_pkg::S_READ;
                end
            end
            lpht_pkg::S_READ: begin
                ram_re  = 1'b1;
                n_state = lpht_pkg::S_CHECK;
            end
            lpht_pkg::S_CHECK: begin
                priority if (!ram_rd.used) begin
                    if (r_kind == lpht_pkg::KIND_INSERT) begin
                        ram_we       = 1'b1;
                        ram_wdata    = '{used: 1'b1, key: r_key};
                        n_fill       = r_fill + FILL_W'(1);
                        n_res_status = lpht_pkg::ST_INSERTED;
                        n_res_slot   = SLOT_W'(r_pos);
                    end else begin
                        n_res_status = lpht_pkg::ST_NOT_FOUND;
                        n_res_slot   = '0;
                    end
                    n_state = lpht_pkg::S_DONE;
                end else if (ram_rd.key == r_key) begin
                    n_res_status = lpht_pkg::ST_FOUND;
                    n_res_slot   = SLOT_W'(r_pos);
                    n_state      = lpht_pkg::S_DONE;
                end else if (r_n == LAST) begin
                    n_res_status = lpht_pkg::ST_FULL;
                    n_res_slot   = '0;
                    n_state      = lpht_pkg::S_DONE;
                end else begin
                    // advance with wrap to the next slot
                    n_pos   = (r_pos == LAST) ? '0 : r_pos + IDX_W'(1);
                    n_n     = r_n + IDX_W'(1);
                    n_state = lpht_pkg::S_READ;
                end
            end
            lpht_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_state      = lpht_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lpht_pkg::S_IDLE;
            end
        endcase
    end

    `LPHT_CHECK(a_fill_bound, r_fill <= FILL_W'(TABLE_SIZE))
    `LPHT_IMPLIES(a_write_state, ram_we, (r_state == lpht_pkg::S_CLEAR) || (r_state == lpht_pkg::S_CHECK))
    `LPHT_NEXT(a_insert_count, (r_state == lpht_pkg::S_CHECK) && ram_we, r_fill == $past(r_fill) + FILL_W'(1))
    `LPHT_NEXT(a_probe_start, accept, (r_n == '0) && (r_state != lpht_pkg::S_IDLE))

endmodule

`default_nettype wire

/* sim/linear_probe_hash_table_test.sv */
// Self-checking bench for linear_probe_hash_table: search and find-or-insert requests
// on 64-bit keys, checked against a probing model of the slot table kept here.
// Depends on lpht_pkg and the hash table RTL.
`timescale 1ns / 1ps

module linear_probe_hash_table_test;
    import lpht_pkg::*;

    localparam int TBL         = TABLE_SIZE_DEF;
    localparam int RANDOM_REQS = 300;
    localparam int HOLD_CYCLES = 3000;
    localparam int MAX_IDLE    = 17;
    localparam int DRAIN       = 64;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
    } lookup_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } lookup_rsp_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;    // key[63:0]
    logic [0:0]  s_axis_tuser  = '0;    // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // slot[9:0], zeros[15:10]
    logic [1:0]  m_axis_tuser;          // status[1:0]

    linear_probe_hash_table #(
        .TABLE_SIZE(TBL)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Slot table as the block should hold it.
    bit               tbl_used [TBL];
    logic [KEY_W-1:0] tbl_key  [TBL];
    bit [10:0]        tbl_fill;

    // Stimulus bookkeeping: keys the stimulus has stored so far.
    bit               key_stored [logic [KEY_W-1:0]];
    logic [KEY_W-1:0] stored_keys[$];

    lookup_req_t lookup_queue[$];
    lookup_rsp_t answer_queue[$];
    lookup_req_t offered;

    int     total_lookups;
    int     lookups_done  = 0;
    int     answers_seen  = 0;
    int     errors        = 0;
    int     src_gap       = 0;
    int     snk_gap       = 0;
    bit     src_calm      = 1'b0;
    bit     snk_calm      = 1'b0;
    int     hold_left     = 0;
    int     next_hold_at  = 300;
    longint cycle_count   = 0;
    longint cycle_limit   = 64'd1 << 40;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Walk the chain from the home slot; store the key in the first empty slot on insert.
    task automatic probe_table(input lookup_req_t req, output lookup_rsp_t rsp);
        int unsigned pos;
        bit          stop;
        pos        = int'(req.key % 64'(TBL));
        stop       = 1'b0;
        rsp.status = ST_FULL;
        rsp.slot   = '0;
        for (int n = 0; n < TBL && !stop; n++) begin
            if (!tbl_used[pos]) begin
                if (req.kind == KIND_INSERT) begin
                    tbl_used[pos] = 1'b1;
                    tbl_key[pos]  = req.key;
                    if (tbl_fill != '1)
                        tbl_fill = tbl_fill + 1'b1;
                    rsp.status = ST_INSERTED;
                    rsp.slot   = pos[SLOT_W-1:0];
                end else begin
                    rsp.status = ST_NOT_FOUND;
                end
                stop = 1'b1;
            end else if (tbl_key[pos] == req.key) begin
                rsp.status = ST_FOUND;
                rsp.slot   = pos[SLOT_W-1:0];
                stop       = 1'b1;
            end else begin
                pos = (pos == TBL - 1) ? 0 : pos + 1;
            end
        end
    endtask

    task automatic add_request(input logic kind, input logic [KEY_W-1:0] key);
        lookup_req_t req;
        req.kind = kind;
        req.key  = key;
        lookup_queue.push_back(req);
        if (kind == KIND_INSERT && !key_stored.exists(key) && stored_keys.size() < TBL) begin
            key_stored[key] = 1'b1;
            stored_keys.push_back(key);
        end
    endtask

    // Random key not yet stored; some land near the top or bottom slots so chains wrap.
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        int unsigned      home;
        do begin
            k = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0: begin
                    home = TBL - 1 - $urandom_range(0, 3);
                    k    = k - k % 64'(TBL) + 64'(home);
                end
                1: begin
                    home = $urandom_range(0, 7);
                    k    = k - k % 64'(TBL) + 64'(home);
                end
                default: ;
            endcase
        end while (key_stored.exists(k));
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] known_key();
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    // Idle cycles before the next item; calm stretches run with none.
    function automatic int draw_idle(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, MAX_IDLE);
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        lookup_rsp_t rsp;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                probe_table(offered, rsp);
                answer_queue.push_back(rsp);
                lookups_done <= lookups_done + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap = src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (lookup_queue.size() != 0) begin
                    offered = lookup_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= offered.key;
                    s_axis_tuser  <= offered.kind;
                    src_gap = draw_idle(src_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        lookup_rsp_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                answers_seen <= answers_seen + 1;
                if (answer_queue.size() == 0) begin
                    $display("%0t: result with no request pending: status %0d, tdata %h",
                             $time, m_axis_tuser, m_axis_tdata);
                    errors++;
                end else begin
                    want = answer_queue.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata !== 16'(want.slot)) begin
                        $display("%0t: tdata (slot) expected %h, actual %h",
                                 $time, 16'(want.slot), m_axis_tdata);
                        errors++;
                    end
                end
                snk_gap = draw_idle(snk_calm);
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap = snk_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-offs so results back up and the input stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (answers_seen >= next_hold_at) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 800;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= cycle_limit) begin
            $display("linear_probe_hash_table_test: done, errors");
            $finish;
        end
    end

    initial begin
        int r;

        // Directed: empty table, duplicates, wrap at the last slot, upper-bit-only differences.
        add_request(KIND_SEARCH, 64'd0);
        add_request(KIND_INSERT, 64'd0);
        add_request(KIND_INSERT, 64'd0);
        add_request(KIND_SEARCH, 64'd0);
        add_request(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(KIND_INSERT, 64'(TBL - 1));
        add_request(KIND_SEARCH, 64'(TBL - 1));
        add_request(KIND_SEARCH, 64'(2 * TBL - 1));
        add_request(KIND_INSERT, 64'(TBL));
        add_request(KIND_INSERT, 64'h8000_0000_0000_0000);
        add_request(KIND_SEARCH, 64'h8000_0000_0000_0000);
        add_request(KIND_SEARCH, 64'h0000_0001_0000_0000);
        add_request(KIND_SEARCH, 64'h8000_0000_0000_03FF);
        add_request(KIND_INSERT, 64'h5555_5555_5555_5555);
        add_request(KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        add_request(KIND_SEARCH, 64'h5555_5555_5555_5555);
        add_request(KIND_SEARCH, 64'hAAAA_AAAA_AAAA_AAAA);
        add_request(KIND_SEARCH, 64'hFFFF_FFFF_FFFF_FFFE);
        add_request(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);

        // Random mix while the table is still lightly loaded.
        for (int i = 0; i < RANDOM_REQS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 48)
                add_request(KIND_INSERT, fresh_key());
            else if (r < 63)
                add_request(KIND_INSERT, known_key());
            else if (r < 83)
                add_request(KIND_SEARCH, known_key());
            else
                add_request(KIND_SEARCH, fresh_key());
        end

        // Fill every slot, then probe the full table.
        while (stored_keys.size() < TBL) begin
            if ($urandom_range(0, 4) == 0)
                add_request(KIND_SEARCH, known_key());
            else
                add_request(KIND_INSERT, fresh_key());
        end
        for (int i = 0; i < 3; i++) begin
            add_request(KIND_INSERT, fresh_key());
            add_request(KIND_SEARCH, fresh_key());
            add_request(KIND_SEARCH, known_key());
            add_request(KIND_INSERT, known_key());
        end

        total_lookups = lookup_queue.size();
        cycle_limit   = 3 * (longint'(TBL) + 4 * HOLD_CYCLES
                        + longint'(total_lookups) * (2 * TBL + 4 + 2 * MAX_IDLE));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (lookups_done < total_lookups || answers_seen < total_lookups)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (errors == 0 && answer_queue.size() == 0) begin
            $display("linear_probe_hash_table_test: done, clean");
        end else begin
            $display("linear_probe_hash_table_test: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/lpht_pkg.sv
sv/lpht_ram.sv
sv/lpht_mod.sv
sv/linear_probe_hash_table.sv
sim/linear_probe_hash_table_test.sv
